### hw/rtl/trrls_pkg.sv
// ----------------------------------------------------------------------------
// trrls_pkg
// Shared types and constants for the thrust ratio RLS estimator.
// ----------------------------------------------------------------------------
package trrls_pkg;

   localparam logic [1:0] ACT_PUSH  = 2'd0;
   localparam logic [1:0] ACT_EST   = 2'd1;
   localparam logic [1:0] ACT_RESET = 2'd2;
   localparam logic [1:0] ACT_NONE  = 2'd3;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_FORGET = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MASS   = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_DLY = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_DLY = 8'd3;

   localparam logic [16:0] FORGET_RST  = 17'd65405;
   localparam logic [23:0] MASS_RST    = 24'd65536;
   localparam logic [19:0] MIN_DLY_RST = 20'd35000;
   localparam logic [19:0] MAX_DLY_RST = 20'd45000;

   localparam logic [30:0] RATIO_ONE = 31'd65536;
   localparam logic [30:0] RATIO_LO  = 31'd13107;
   localparam logic [30:0] RATIO_HI  = 31'd131072;
   localparam logic [47:0] COV_INIT  = 48'd16777216000000;

   localparam int OP_W   = 64;
   localparam int PROD_W = 128;
   localparam int DIV_W  = 128;

   typedef struct packed {
      logic            go;
      logic [OP_W-1:0] a;
      logic [OP_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic             go;
      logic [DIV_W-1:0] n;
      logic [DIV_W-1:0] d;
   } div_req_type;

endpackage

### hw/rtl/trrls_mul.sv
// ----------------------------------------------------------------------------
// trrls_mul
// Shift-add multiplier, 64 x 64 to 128 bits, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module trrls_mul (
   input  logic                            clock,
   input  logic                            reset,
   input  trrls_pkg::mul_req_type          req,
   output logic                            done,
   output logic [trrls_pkg::PROD_W-1:0]    prod
);

   logic                           run_ff;
   logic                           done_ff;
   logic [5:0]                     cnt_ff;
   logic [trrls_pkg::PROD_W-1:0]   acc_ff;
   logic [trrls_pkg::PROD_W-1:0]   a_ff;
   logic [trrls_pkg::OP_W-1:0]     b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.go) begin
            run_ff <= 1'b1;
            cnt_ff <= 6'd63;
            acc_ff <= '0;
            a_ff   <= {64'd0, req.a};
            b_ff   <= req.b;
         end else if (run_ff) begin
            if (b_ff[0]) begin
               acc_ff <= acc_ff + a_ff;
            end
            a_ff   <= {a_ff[126:0], 1'b0};
            b_ff   <= {1'b0, b_ff[63:1]};
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

### hw/rtl/trrls_div.sv
// ----------------------------------------------------------------------------
// trrls_div
// Restoring divider, 128 / 128 bits, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module trrls_div (
   input  logic                            clock,
   input  logic                            reset,
   input  trrls_pkg::div_req_type          req,
   output logic                            done,
   output logic [trrls_pkg::DIV_W-1:0]     quot
);

   logic                          run_ff;
   logic                          done_ff;
   logic [6:0]                    cnt_ff;
   logic [trrls_pkg::DIV_W-1:0]   rem_ff;
   logic [trrls_pkg::DIV_W-1:0]   num_ff;
   logic [trrls_pkg::DIV_W-1:0]   den_ff;
   logic [trrls_pkg::DIV_W-1:0]   quot_ff;
   logic [trrls_pkg::DIV_W:0]     trial;
   logic [trrls_pkg::DIV_W:0]     diff;
   logic                          ge;

   assign trial = {rem_ff, num_ff[127]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.go) begin
            run_ff  <= 1'b1;
            cnt_ff  <= 7'd127;
            rem_ff  <= '0;
            num_ff  <= req.n;
            den_ff  <= req.d;
            quot_ff <= '0;
         end else if (run_ff) begin
            rem_ff  <= ge ? diff[127:0] : trial[127:0];
            quot_ff <= {quot_ff[126:0], ge};
            num_ff  <= {num_ff[126:0], 1'b0};
            cnt_ff  <= cnt_ff - 7'd1;
            if (cnt_ff == 7'd0) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

### hw/rtl/thrust_ratio_rls_estimator.sv
// ----------------------------------------------------------------------------
// thrust_ratio_rls_estimator
// Sample queue in one synchronous memory, sequencer, shared serial multiplier
// and divider. One item at a time: a push runs a multiply and then a divide, a
// reset item a divide, and an estimate drops stale entries and, unless the
// oldest is too young, runs an RLS update on the multiplier and divider.
// Synchronous reset empties the queue, sets ratio to one and covariance to
// 1e6; the result strobe cannot be stalled.
// ----------------------------------------------------------------------------
module thrust_ratio_rls_estimator #(
   parameter int QUEUE_DEPTH = 128
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_action,
   input  logic [39:0]                          req_time_us,
   input  logic signed [31:0]                   req_thrust_force,
   input  logic signed [31:0]                   req_accel_z,
   output logic                                 rsp_valid,
   output logic signed [31:0]                   rsp_throttle,
   output logic                                 rsp_updated,
   output logic [30:0]                          rsp_ratio,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [trrls_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [trrls_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

   typedef enum logic [3:0] {
      S_IDLE, S_PUSH_MUL, S_PUSH_DIV, S_RST_DIV, S_EST_LOOP, S_EST_CHK,
      S_RLS_SQ, S_RLS_DEN, S_RLS_PT, S_RLS_K, S_RLS_TR, S_RLS_ERR,
      S_RLS_CORR, S_RLS_COV
   } state_type;

   state_type                   state_ff;
   logic [39:0]                 now_ff;
   logic signed [31:0]          force_ff;
   logic signed [31:0]          accel_ff;

   logic [16:0]                 forget_ff;
   logic [23:0]                 mass_ff;
   logic [19:0]                 min_dly_ff;
   logic [19:0]                 max_dly_ff;

   logic [AW-1:0]               head_ff;
   logic [CW-1:0]               count_ff;
   logic [30:0]                 ratio_ff;
   logic [47:0]                 cov_ff;

   logic [71:0]                 sample_mem [QUEUE_DEPTH];
   logic [71:0]                 rd_data_ff;

   logic                        thr_neg_ff;
   logic [31:0]                 tm_ff;
   logic [111:0]                den_ff;
   logic [62:0]                 kmag_ff;
   logic signed [65:0]          err_ff;
   logic                        neg_ff;

   logic                        rsp_valid_ff;
   logic signed [31:0]          rsp_throttle_ff;
   logic                        rsp_updated_ff;

   trrls_pkg::mul_req_type      mul_req_ff;
   trrls_pkg::div_req_type      div_req_ff;
   logic                        mul_done;
   logic                        div_done;
   logic [127:0]                prod;
   logic [127:0]                quot;

   trrls_mul u_mul (
      .clock (clock), .reset (reset), .req (mul_req_ff), .done (mul_done), .prod (prod)
   );

   trrls_div u_div (
      .clock (clock), .reset (reset), .req (div_req_ff), .done (div_done), .quot (quot)
   );

   // derived values
   logic [23:0]         mass_eff;
   logic [16:0]         rho_eff;
   logic [31:0]         force_mag;
   logic signed [31:0]  push_thr;
   logic [AW-1:0]       head_inc;
   logic [CW:0]         slot_sum;
   logic [AW-1:0]       slot;
   logic [39:0]         rd_time;
   logic signed [31:0]  rd_thr;
   logic [39:0]         age;
   logic [63:0]         err_mag;
   logic [40:0]         dmag;
   logic signed [42:0]  ratio_sum;
   logic [30:0]         ratio_clip;
   logic [30:0]         ratio_rst;
   logic signed [65:0]  err_calc;
   logic signed [65:0]  tr_signed;

   assign mass_eff  = (mass_ff == 24'd0) ? 24'd1 : mass_ff;
   assign rho_eff   = (forget_ff == 17'd0) ? 17'd1 : forget_ff;
   assign force_mag = force_ff[31] ? 32'(-$signed({force_ff[31], force_ff}))
                                   : 32'(force_ff);

   always_comb begin
      if (ratio_ff == 31'd0) begin
         push_thr = force_ff;
      end else if (force_ff[31]) begin
         push_thr = (quot > 128'h8000_0000) ? 32'sh8000_0000
                                            : 32'(-$signed({1'b0, quot[31:0]}));
      end else begin
         push_thr = (quot > 128'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(quot[31:0]);
      end
   end

   assign head_inc = (head_ff == LAST) ? '0 : head_ff + AW'(1);
   assign slot_sum = {1'b0, (CW)'(head_ff)} + {1'b0, count_ff};
   assign slot     = (slot_sum >= (CW + 1)'(QUEUE_DEPTH))
                     ? AW'(slot_sum - (CW + 1)'(QUEUE_DEPTH)) : AW'(slot_sum);

   assign rd_time = rd_data_ff[39:0];
   assign rd_thr  = $signed(rd_data_ff[71:40]);
   assign age     = (now_ff >= rd_time) ? now_ff - rd_time : 40'd0;

   assign tr_signed = thr_neg_ff ? -$signed({3'b0, prod[62:0]})
                                 : $signed({3'b0, prod[62:0]});
   assign err_calc  = $signed({{18{accel_ff[31]}}, accel_ff, 16'd0}) - tr_signed;
   assign err_mag   = err_ff[65] ? 64'(-err_ff) : err_ff[63:0];

   assign dmag = (prod[127:48] > 80'h100_0000_0000) ? 41'h100_0000_0000 : prod[88:48];
   assign ratio_sum = neg_ff ? $signed({12'd0, ratio_ff}) - $signed({2'd0, dmag})
                             : $signed({12'd0, ratio_ff}) + $signed({2'd0, dmag});
   always_comb begin
      if (ratio_sum < $signed({12'd0, trrls_pkg::RATIO_LO})) begin
         ratio_clip = trrls_pkg::RATIO_LO;
      end else if (ratio_sum > $signed({12'd0, trrls_pkg::RATIO_HI})) begin
         ratio_clip = trrls_pkg::RATIO_HI;
      end else begin
         ratio_clip = ratio_sum[30:0];
      end
   end

   assign ratio_rst = (quot > 128'h7FFF_FFFF) ? 31'h7FFF_FFFF : quot[30:0];

   // sample memory
   always_ff @(posedge clock) begin
      if (state_ff == S_PUSH_DIV && div_done) begin
         sample_mem[(count_ff >= FULL) ? head_ff : slot] <= {push_thr, now_ff};
      end
      rd_data_ff <= sample_mem[head_ff];
   end

   // configuration
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         forget_ff  <= trrls_pkg::FORGET_RST;
         mass_ff    <= trrls_pkg::MASS_RST;
         min_dly_ff <= trrls_pkg::MIN_DLY_RST;
         max_dly_ff <= trrls_pkg::MAX_DLY_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            trrls_pkg::CSR_FORGET:  forget_ff  <= csr_wdata[16:0];
            trrls_pkg::CSR_MASS:    mass_ff    <= csr_wdata[23:0];
            trrls_pkg::CSR_MIN_DLY: min_dly_ff <= csr_wdata[19:0];
            trrls_pkg::CSR_MAX_DLY: max_dly_ff <= csr_wdata[19:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         ratio_ff     <= trrls_pkg::RATIO_ONE;
         cov_ff       <= trrls_pkg::COV_INIT;
         rsp_valid_ff <= 1'b0;
         mul_req_ff   <= '0;
         div_req_ff   <= '0;
      end else begin
         rsp_valid_ff  <= 1'b0;
         mul_req_ff.go <= 1'b0;
         div_req_ff.go <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  now_ff   <= req_time_us;
                  force_ff <= req_thrust_force;
                  accel_ff <= req_accel_z;
                  unique case (req_action)
                     trrls_pkg::ACT_PUSH: begin
                        mul_req_ff <= '{1'b1, {40'd0, mass_eff}, {33'd0, ratio_ff}};
                        state_ff   <= S_PUSH_MUL;
                     end
                     trrls_pkg::ACT_EST: begin
                        state_ff <= S_EST_LOOP;
                     end
                     trrls_pkg::ACT_RESET: begin
                        div_req_ff <= '{1'b1, 128'h1_0000_0000, {104'd0, mass_eff}};
                        state_ff   <= S_RST_DIV;
                     end
                     default: begin
                        rsp_valid_ff    <= 1'b1;
                        rsp_throttle_ff <= '0;
                        rsp_updated_ff  <= 1'b0;
                     end
                  endcase
               end
            end
            S_PUSH_MUL: begin
               if (mul_done) begin
                  div_req_ff <= '{1'b1, {64'd0, force_mag, 32'd0}, {64'd0, prod[63:0]}};
                  state_ff   <= S_PUSH_DIV;
               end
            end
            S_PUSH_DIV: begin
               if (div_done) begin
                  if (count_ff >= FULL) begin
                     head_ff <= head_inc;
                  end else begin
                     count_ff <= count_ff + CW'(1);
                  end
                  rsp_valid_ff    <= 1'b1;
                  rsp_throttle_ff <= push_thr;
                  rsp_updated_ff  <= 1'b0;
                  state_ff        <= S_IDLE;
               end
            end
            S_RST_DIV: begin
               if (div_done) begin
                  ratio_ff        <= ratio_rst;
                  cov_ff          <= trrls_pkg::COV_INIT;
                  rsp_valid_ff    <= 1'b1;
                  rsp_throttle_ff <= '0;
                  rsp_updated_ff  <= 1'b0;
                  state_ff        <= S_IDLE;
               end
            end
            S_EST_LOOP: begin
               if (count_ff == '0) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_throttle_ff <= '0;
                  rsp_updated_ff  <= 1'b0;
                  state_ff        <= S_IDLE;
               end else begin
                  state_ff <= S_EST_CHK;
               end
            end
            S_EST_CHK: begin
               if (age > {20'd0, max_dly_ff}) begin
                  head_ff  <= head_inc;
                  count_ff <= count_ff - CW'(1);
                  state_ff <= S_EST_LOOP;
               end else if (age < {20'd0, min_dly_ff}) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_throttle_ff <= '0;
                  rsp_updated_ff  <= 1'b0;
                  state_ff        <= S_IDLE;
               end else begin
                  head_ff    <= head_inc;
                  count_ff   <= count_ff - CW'(1);
                  thr_neg_ff <= rd_thr[31];
                  tm_ff      <= rd_thr[31] ? 32'(-$signed({rd_thr[31], rd_thr}))
                                           : 32'(rd_thr);
                  mul_req_ff <= '{1'b1, 64'(rd_thr[31] ? 32'(-$signed({rd_thr[31], rd_thr}))
                                                      : 32'(rd_thr)),
                                  64'(rd_thr[31] ? 32'(-$signed({rd_thr[31], rd_thr}))
                                                 : 32'(rd_thr))};
                  state_ff   <= S_RLS_SQ;
               end
            end
            S_RLS_SQ: begin
               if (mul_done) begin
                  mul_req_ff <= '{1'b1, prod[63:0], {16'd0, cov_ff}};
                  state_ff   <= S_RLS_DEN;
               end
            end
            S_RLS_DEN: begin
               if (mul_done) begin
                  den_ff     <= prod[111:0] + {55'd0, rho_eff, 40'd0};
                  mul_req_ff <= '{1'b1, {16'd0, cov_ff}, {32'd0, tm_ff}};
                  state_ff   <= S_RLS_PT;
               end
            end
            S_RLS_PT: begin
               if (mul_done) begin
                  div_req_ff <= '{1'b1, {prod[79:0], 48'd0}, {16'd0, den_ff}};
                  state_ff   <= S_RLS_K;
               end
            end
            S_RLS_K: begin
               if (div_done) begin
                  kmag_ff    <= (quot > 128'h4000_0000_0000_0000)
                                ? 63'h4000_0000_0000_0000 : quot[62:0];
                  mul_req_ff <= '{1'b1, {32'd0, tm_ff}, {33'd0, ratio_ff}};
                  state_ff   <= S_RLS_TR;
               end
            end
            S_RLS_TR: begin
               if (mul_done) begin
                  err_ff   <= err_calc;
                  state_ff <= S_RLS_ERR;
               end
            end
            S_RLS_ERR: begin
               neg_ff     <= thr_neg_ff ^ err_ff[65];
               mul_req_ff <= '{1'b1, {1'b0, kmag_ff}, err_mag};
               state_ff   <= S_RLS_CORR;
            end
            S_RLS_CORR: begin
               if (mul_done) begin
                  ratio_ff   <= ratio_clip;
                  div_req_ff <= '{1'b1, {24'd0, cov_ff, 56'd0}, {16'd0, den_ff}};
                  state_ff   <= S_RLS_COV;
               end
            end
            S_RLS_COV: begin
               if (div_done) begin
                  cov_ff          <= (quot[127:48] != '0) ? 48'hFFFF_FFFF_FFFF : quot[47:0];
                  rsp_valid_ff    <= 1'b1;
                  rsp_throttle_ff <= '0;
                  rsp_updated_ff  <= 1'b1;
                  state_ff        <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy         = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_throttle = rsp_throttle_ff;
   assign rsp_updated  = rsp_updated_ff;
   assign rsp_ratio    = ratio_ff;

endmodule
